// ===== hw/rtl/slq_pkg.sv =====
package slq_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;

	// Commands from the controller to the datapath, one cycle at a time.
	typedef struct packed {
		logic load;           // capture the operand and clear the result flags
		logic idx_zero;       // index register to slot 0
		logic idx_from_count; // index register to the fill count
		logic idx_inc;
		logic idx_dec;
		logic rd;             // registered read of the entry memory
		logic addr_prev;      // address idx-1 instead of idx
		logic addr_next;      // address idx+1 instead of idx
		logic wr_rdata;       // write the last read entry at idx
		logic wr_value;       // write the operand at idx
		logic cnt_inc;
		logic cnt_dec;
		logic take_popped;    // last read entry becomes the popped value
		logic set_found;
		logic set_refused;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic idx_zero;
		logic idx_at_count;
		logic idx_last;       // idx+1 equals the fill count
		logic rd_lt;          // last read entry is less than the operand
		logic rd_eq;          // last read entry equals the operand
	} dp_status_t;

endpackage

// ===== hw/rtl/slq_datapath.sv =====
module slq_datapath
	import slq_pkg::*;
#(
	parameter int CAPACITY = 16,
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic signed [31:0] value,
	output dp_status_t         status,
	output logic signed [31:0] popped_value,
	output logic               popped_valid,
	output logic               removal_found,
	output logic               insert_refused,
	output logic               is_empty,
	output logic [4:0]         entry_count
);

	logic [31:0]        mem [CAPACITY];
	logic [31:0]        rdata_q;
	logic signed [31:0] value_q;
	logic signed [31:0] popped_value_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	logic               popped_valid_q;
	logic               found_q;
	logic               refused_q;
	logic [CW-1:0]      addr_wide;
	logic [IW-1:0]      mem_addr;
	logic [CW-1:0]      idx_plus1;

	assign idx_plus1 = idx_q + CW'(1);

	always_comb begin
		priority if (cmd.addr_prev) begin
			addr_wide = idx_q - CW'(1);
		end else if (cmd.addr_next) begin
			addr_wide = idx_plus1;
		end else begin
			addr_wide = idx_q;
		end
	end

	assign mem_addr = addr_wide[IW-1:0];

	// Single-port entry store with a registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr_rdata) begin
			mem[mem_addr] <= rdata_q;
		end else if (cmd.wr_value) begin
			mem[mem_addr] <= value_q;
		end
		if (cmd.rd) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
		end
		if (cmd.idx_zero) begin
			idx_q <= '0;
		end else if (cmd.idx_from_count) begin
			idx_q <= count_q;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_plus1;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end
		if (cmd.load) begin
			popped_value_q <= '0;
		end else if (cmd.take_popped) begin
			popped_value_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			popped_valid_q <= 1'b0;
			found_q        <= 1'b0;
			refused_q      <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			// A flag set in the load cycle itself wins over the clear.
			if (cmd.take_popped) begin
				popped_valid_q <= 1'b1;
			end else if (cmd.load) begin
				popped_valid_q <= 1'b0;
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end else if (cmd.load) begin
				found_q <= 1'b0;
			end
			if (cmd.set_refused) begin
				refused_q <= 1'b1;
			end else if (cmd.load) begin
				refused_q <= 1'b0;
			end
		end
	end

	assign status.full         = (count_q == CW'(CAPACITY));
	assign status.empty        = (count_q == '0);
	assign status.idx_zero     = (idx_q == '0);
	assign status.idx_at_count = (idx_q == count_q);
	assign status.idx_last     = (idx_plus1 == count_q);
	assign status.rd_lt        = ($signed(rdata_q) < value_q);
	assign status.rd_eq        = ($signed(rdata_q) == value_q);

	assign popped_value   = popped_value_q;
	assign popped_valid   = popped_valid_q;
	assign removal_found  = found_q;
	assign insert_refused = refused_q;
	assign is_empty       = (count_q == '0);
	assign entry_count    = 5'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the fill count by one");

endmodule

// ===== hw/rtl/slq_controller.sv =====
module slq_controller
	import slq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_POP_RD,
		S_POP_TAKE,
		S_DEL_RD,
		S_DEL_WR
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   finish;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (command)
						CMD_INSERT: begin
							if (status.full) begin
								cmd.set_refused = 1'b1;
								finish          = 1'b1;
							end else begin
								cmd.idx_from_count = 1'b1;
								state_n            = S_INS_RD;
							end
						end
						CMD_REMOVE: begin
							cmd.idx_zero = 1'b1;
							state_n      = S_SCAN_RD;
						end
						CMD_POP: begin
							if (status.empty) begin
								finish = 1'b1;
							end else begin
								cmd.idx_zero = 1'b1;
								state_n      = S_POP_RD;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			// Insert walks down from the top, moving entries not less than the operand up one slot.
			S_INS_RD: begin
				if (status.idx_zero) begin
					cmd.wr_value = 1'b1;
					cmd.cnt_inc  = 1'b1;
					finish       = 1'b1;
				end else begin
					cmd.rd        = 1'b1;
					cmd.addr_prev = 1'b1;
					state_n       = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (status.rd_lt) begin
					cmd.wr_value = 1'b1;
					cmd.cnt_inc  = 1'b1;
					finish       = 1'b1;
				end else begin
					cmd.wr_rdata = 1'b1;
					cmd.idx_dec  = 1'b1;
					state_n      = S_INS_RD;
				end
			end
			S_SCAN_RD: begin
				if (status.idx_at_count) begin
					finish = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					state_n = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				priority if (status.rd_lt) begin
					cmd.idx_inc = 1'b1;
					state_n     = S_SCAN_RD;
				end else if (status.rd_eq) begin
					cmd.set_found = 1'b1;
					state_n       = S_DEL_RD;
				end else begin
					finish = 1'b1;
				end
			end
			S_POP_RD: begin
				cmd.rd  = 1'b1;
				state_n = S_POP_TAKE;
			end
			S_POP_TAKE: begin
				cmd.take_popped = 1'b1;
				state_n         = S_DEL_RD;
			end
			// Deletion closes the gap by moving each later entry down one slot.
			S_DEL_RD: begin
				if (status.idx_last) begin
					cmd.cnt_dec = 1'b1;
					finish      = 1'b1;
				end else begin
					cmd.rd        = 1'b1;
					cmd.addr_next = 1'b1;
					state_n       = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				cmd.wr_rdata = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_n      = S_DEL_RD;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		if (finish) begin
			state_n = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			busy_q  <= (state_n != S_IDLE);
			done_q  <= finish;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && busy_q))
		else $error("result strobe while still working");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (busy_q || done_q))
		else $error("accepted command neither ran nor finished");

endmodule

// ===== hw/rtl/sorted_list_queue.sv =====
// Sorted-list priority queue holding up to CAPACITY signed 32-bit values in
// ascending order. Duplicates are kept.
// Command channel: a transfer happens at a rising edge with start high and busy
// low. command selects insert, remove one occurrence of value, or pop smallest.
// Result channel: done is high for exactly one cycle per command, and the
// result ports hold popped_value, popped_valid, removal_found, insert_refused,
// is_empty and entry_count for that cycle. The receiver cannot stall, so the
// result must be taken in that cycle; busy is already low then and the next
// command may be transferred in the same cycle.
// Timing: a refused insert, a pop of an empty store or an unused code gives done
// in the cycle after the transfer. Every other command reads each entry that it
// compares or moves before acting on it, since the entries live in a single-port
// memory with a registered read; its run time grows with the entries touched.
// One command is worked on at a time.
// Reset empties the store; the memory contents are not cleared.
module sorted_list_queue
	import slq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] popped_value,
	output logic               popped_valid,
	output logic               removal_found,
	output logic               insert_refused,
	output logic               is_empty,
	output logic [4:0]         entry_count
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	slq_controller u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (dp_status),
		.cmd     (dp_cmd),
		.busy    (busy),
		.done    (done)
	);

	slq_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.value          (value),
		.status         (dp_status),
		.popped_value   (popped_value),
		.popped_valid   (popped_valid),
		.removal_found  (removal_found),
		.insert_refused (insert_refused),
		.is_empty       (is_empty),
		.entry_count    (entry_count)
	);

endmodule

// ===== test/sorted_list_queue_tb.sv =====
module sorted_list_queue_tb;
	import slq_pkg::*;

	localparam int CAPACITY = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1300;
	localparam int CALM_ITEMS = 200;
	localparam int SETTLE_CYCLES = 4 * CAPACITY + 16;
	localparam int MAX_REPORTS = 50;

	typedef struct {
		logic signed [31:0] popped_value;
		logic               popped_valid;
		logic               removal_found;
		logic               insert_refused;
		logic               is_empty;
		logic [4:0]         entry_count;
	} queue_result_t;

	class sorted_queue_checker;
		logic signed [31:0] held_values[$];
		queue_result_t      awaited_results[$];
		int unsigned        errors = 0;

		// Works out the result of one accepted command and updates the held values.
		function void take_command(logic [1:0] cmd, logic signed [31:0] val);
			queue_result_t r;
			int slot;
			r = '{default: 0};
			slot = 0;
			// First held value that is not less than the operand.
			while (slot < held_values.size() && held_values[slot] < val)
				slot++;
			case (cmd)
				CMD_INSERT: begin
					if (held_values.size() >= CAPACITY)
						r.insert_refused = 1'b1;
					else
						held_values.insert(slot, val);
				end
				CMD_REMOVE: begin
					if (slot < held_values.size() && held_values[slot] == val) begin
						held_values.delete(slot);
						r.removal_found = 1'b1;
					end
				end
				CMD_POP: begin
					if (held_values.size() > 0) begin
						r.popped_value = held_values.pop_front();
						r.popped_valid = 1'b1;
					end
				end
				default: ;
			endcase
			r.is_empty = (held_values.size() == 0);
			r.entry_count = 5'(held_values.size());
			awaited_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			end
		endfunction

		function void check_result(queue_result_t got);
			queue_result_t want;
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with no command outstanding, expected none, actual %h",
						$time, got.popped_value);
				return;
			end
			want = awaited_results.pop_front();
			compare_field("popped_value", want.popped_value, got.popped_value);
			compare_field("popped_valid", 32'(want.popped_valid), 32'(got.popped_valid));
			compare_field("removal_found", 32'(want.removal_found), 32'(got.removal_found));
			compare_field("insert_refused", 32'(want.insert_refused),
				32'(got.insert_refused));
			compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
			compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         command = CMD_INSERT;
	logic signed [31:0] value = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] popped_value;
	logic               popped_valid;
	logic               removal_found;
	logic               insert_refused;
	logic               is_empty;
	logic [4:0]         entry_count;

	sorted_queue_checker book;

	sorted_list_queue #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.done(done),
		.popped_value(popped_value),
		.popped_valid(popped_valid),
		.removal_found(removal_found),
		.insert_refused(insert_refused),
		.is_empty(is_empty),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both the command transfer and the result are taken here, so their order
	// within one edge is fixed.
	always @(posedge clk) begin : watch
		queue_result_t got;
		if (arst_n) begin
			if (start && !busy)
				book.take_command(command, value);
			if (done) begin
				got.popped_value = popped_value;
				got.popped_valid = popped_valid;
				got.removal_found = removal_found;
				got.insert_refused = insert_refused;
				got.is_empty = is_empty;
				got.entry_count = entry_count;
				book.check_result(got);
			end
		end
	end

	task automatic send(logic [1:0] cmd, logic signed [31:0] val);
		start <= 1'b1;
		command <= cmd;
		value <= val;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds off until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		while (book.awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		int unsigned roll = $urandom_range(99);
		if (roll < 25 && book.held_values.size() > 0)
			return book.held_values[$urandom_range(book.held_values.size() - 1)];
		if (roll < 55)
			return $urandom_range(8) - 4;
		if (roll < 65)
			return 32'h7ffffffe + $urandom_range(3);
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_command(bit growing);
		int unsigned roll = $urandom_range(99);
		if (roll < 3)
			return CMD_UNUSED;
		if (roll < (growing ? 70 : 30))
			return CMD_INSERT;
		if (roll < (growing ? 85 : 65))
			return CMD_REMOVE;
		return CMD_POP;
	endfunction

	initial begin
		bit growing;
		int unsigned idle_pct;
		book = new;
		growing = 1'b1;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store, unused code, extremes, duplicates, found and absent removals.
		send(CMD_POP, 0);
		send(CMD_REMOVE, 7);
		send(CMD_UNUSED, -1);
		send(CMD_INSERT, 32'sh7fffffff);
		send(CMD_INSERT, 32'sh80000000);
		send(CMD_INSERT, 0);
		send(CMD_INSERT, 0);
		send(CMD_INSERT, -1);
		send(CMD_REMOVE, 0);
		send(CMD_REMOVE, 1);
		send(CMD_REMOVE, 32'sh7fffffff);
		send(CMD_POP, 32'sh5a5a5a5a);
		// Fill the store, then insert into a full one.
		for (int k = 0; k < CAPACITY - 2; k++)
			send(CMD_INSERT, 3 * k - 20);
		send(CMD_INSERT, 5);
		send(CMD_UNUSED, 0);
		send(CMD_REMOVE, 32'sh7fffffff);
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Pick a filling or draining phase at random every 60 items so both full and
			// empty stores are visited often.
			if (n % 60 == 0) begin
				growing = 1'($urandom_range(1));
				idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
			end
			if (n == RANDOM_ITEMS / 2)
				drain();
			if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(99) < idle_pct)
				pause($urandom_range(16, 1));
			send(pick_command(growing), pick_value());
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#6000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
